// ===== hdl/bcd_pkg.sv =====
package bcd_pkg;

  localparam int unsigned PRESCALER_STEPS_DEF = 16;
  localparam int unsigned DIVIDER_STEPS_DEF   = 8;

  localparam int unsigned CLK_W = 32;
  localparam int unsigned PSC_W = 4;
  localparam int unsigned BDV_W = 3;
  // (1+p)*(1+d)*2 peaks at 16*8*2 = 256
  localparam int unsigned DVS_W = 9;
  localparam int unsigned BIT_W = $clog2(CLK_W);

  typedef logic [CLK_W-1:0] hz_t;
  typedef logic [PSC_W-1:0] psc_t;
  typedef logic [BDV_W-1:0] bdv_t;
  typedef logic [DVS_W-1:0] dvs_t;
  typedef logic [BIT_W-1:0] bitcnt_t;

  typedef enum logic [2:0] {
    S_FETCH = 3'd0,
    S_SETUP = 3'd1,
    S_DIV   = 3'd2,
    S_CMP   = 3'd3,
    S_NEXT  = 3'd4,
    S_EMIT  = 3'd5,
    S_RET   = 3'd6
  } step_t;

  typedef enum logic [2:0] {
    C_NONE     = 3'd0,
    C_IN_WAIT  = 3'd1,
    C_DIV_BUSY = 3'd2,
    C_MORE     = 3'd3,
    C_OUT_BUSY = 3'd4,
    C_ALWAYS   = 3'd5
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  ld_in;
    logic  ld_div;
    logic  div;
    logic  cmp;
    logic  adv;
    logic  emit;
  } uword_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{cond: C_NONE, target: S_FETCH, default: 1'b0};
    unique case (s)
      S_FETCH: begin
        w.ld_in = 1'b1; w.cond = C_IN_WAIT; w.target = S_FETCH;
      end
      S_SETUP: begin
        w.ld_div = 1'b1;
      end
      S_DIV: begin
        w.div = 1'b1; w.cond = C_DIV_BUSY; w.target = S_DIV;
      end
      S_CMP: begin
        w.cmp = 1'b1;
      end
      S_NEXT: begin
        w.adv = 1'b1; w.cond = C_MORE; w.target = S_SETUP;
      end
      S_EMIT: begin
        w.emit = 1'b1; w.cond = C_OUT_BUSY; w.target = S_EMIT;
      end
      S_RET: begin
        w.cond = C_ALWAYS; w.target = S_FETCH;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/bcd_if.sv =====
interface bcd_in_if;
  logic            valid;
  logic            ready;
  bcd_pkg::hz_t    reference_clock_hz;
  bcd_pkg::hz_t    target_bit_clock_hz;

  modport source (output valid, output reference_clock_hz, output target_bit_clock_hz,
                  input ready);
  modport sink   (input valid, input reference_clock_hz, input target_bit_clock_hz,
                  output ready);
endinterface

interface bcd_out_if;
  logic            valid;
  logic            ready;
  bcd_pkg::psc_t   prescaler_select;
  bcd_pkg::bdv_t   bit_divider_select;

  modport source (output valid, output prescaler_select, output bit_divider_select,
                  input ready);
  modport sink   (input valid, input prescaler_select, input bit_divider_select,
                  output ready);
endinterface

// ===== hdl/bit_clock_divider_search_top.sv =====
// Accepts one word at a time and takes no new word until its result has been emitted;
// each candidate is 1 setup, 32 restoring divide steps, 1 compare, 1 advance.
// The search is done by the bit-serial divider; a finished word may wait in the output
// register while the next word is accepted and searched.
// Reset (rst_n low, synchronous): step counter to fetch, output valid cleared.
module bit_clock_divider_search_top #(
  parameter int unsigned PRESCALER_STEPS = bcd_pkg::PRESCALER_STEPS_DEF,
  parameter int unsigned DIVIDER_STEPS   = bcd_pkg::DIVIDER_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bcd_in_if.sink      in_ch,
  bcd_out_if.source   out_ch
);

  localparam bcd_pkg::psc_t P_LAST = bcd_pkg::PSC_W'(PRESCALER_STEPS - 1);
  localparam bcd_pkg::bdv_t D_LAST = bcd_pkg::BDV_W'(DIVIDER_STEPS - 1);
  localparam bcd_pkg::bitcnt_t BIT_LAST = bcd_pkg::BIT_W'(bcd_pkg::CLK_W - 1);

  bcd_pkg::step_t   pc_r, pc_nxt;
  bcd_pkg::uword_t  uw;

  bcd_pkg::hz_t     refclk_r, target_r, quo_r, best_r;
  bcd_pkg::dvs_t    rem_r, dvs_r;
  bcd_pkg::bitcnt_t bit_r;
  bcd_pkg::psc_t    p_r, best_p_r, out_p_r;
  bcd_pkg::bdv_t    d_r, best_d_r, out_d_r;
  logic             out_valid_r;

  logic             out_busy, in_fire, emit_fire, more, cond_hit;
  bcd_pkg::dvs_t    trial, p_ext, d_ext, prod;
  bcd_pkg::hz_t     delta;

  assign uw        = bcd_pkg::ucode(pc_r);
  assign out_busy  = out_valid_r && !out_ch.ready;
  assign in_fire   = uw.ld_in && in_ch.valid;
  assign emit_fire = uw.emit && !out_busy;
  assign more      = !((p_r == P_LAST) && (d_r == D_LAST));

  // sequencer
  always_comb begin
    unique case (uw.cond)
      bcd_pkg::C_NONE:     cond_hit = 1'b0;
      bcd_pkg::C_IN_WAIT:  cond_hit = !in_ch.valid;
      bcd_pkg::C_DIV_BUSY: cond_hit = (bit_r != BIT_LAST);
      bcd_pkg::C_MORE:     cond_hit = more;
      bcd_pkg::C_OUT_BUSY: cond_hit = out_busy;
      bcd_pkg::C_ALWAYS:   cond_hit = 1'b1;
      default:             cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = bcd_pkg::step_t'(pc_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bcd_pkg::S_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // datapath
  assign p_ext = bcd_pkg::DVS_W'(p_r) + bcd_pkg::DVS_W'(1);
  assign d_ext = bcd_pkg::DVS_W'(d_r) + bcd_pkg::DVS_W'(1);
  assign prod  = bcd_pkg::DVS_W'(p_ext * d_ext);
  assign trial = {rem_r[bcd_pkg::DVS_W-2:0], quo_r[bcd_pkg::CLK_W-1]};
  assign delta = (quo_r > target_r) ? (quo_r - target_r) : (target_r - quo_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      refclk_r <= in_ch.reference_clock_hz;
      target_r <= in_ch.target_bit_clock_hz;
      best_r   <= '1;
      best_p_r <= '0;
      best_d_r <= '0;
      p_r      <= '0;
      d_r      <= '0;
    end
    if (uw.ld_div) begin
      dvs_r <= {prod[bcd_pkg::DVS_W-2:0], 1'b0};
      rem_r <= '0;
      quo_r <= refclk_r;
      bit_r <= '0;
    end
    if (uw.div) begin
      if (trial >= dvs_r) begin
        rem_r <= trial - dvs_r;
        quo_r <= {quo_r[bcd_pkg::CLK_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[bcd_pkg::CLK_W-2:0], 1'b0};
      end
      bit_r <= bit_r + bcd_pkg::BIT_W'(1);
    end
    if (uw.cmp && (delta < best_r)) begin
      best_r   <= delta;
      best_p_r <= p_r;
      best_d_r <= d_r;
    end
    if (uw.adv) begin
      if (d_r == D_LAST) begin
        d_r <= '0;
        p_r <= p_r + bcd_pkg::PSC_W'(1);
      end else begin
        d_r <= d_r + bcd_pkg::BDV_W'(1);
      end
    end
    if (emit_fire) begin
      out_p_r <= best_p_r;
      out_d_r <= best_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_ch.ready               = uw.ld_in;
  assign out_ch.valid              = out_valid_r;
  assign out_ch.prescaler_select   = out_p_r;
  assign out_ch.bit_divider_select = out_d_r;

endmodule

// ===== hdl/bcd_checker.sv =====
module bcd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input bcd_pkg::psc_t prescaler_select,
  input bcd_pkg::bdv_t bit_divider_select
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(prescaler_select) && $stable(bit_divider_select))
    else $error("out word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted during search");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared right after accept");

endmodule

bind bit_clock_divider_search_top bcd_checker u_bcd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .prescaler_select   (out_ch.prescaler_select),
  .bit_divider_select (out_ch.bit_divider_select)
);
